// ----- hdl/photometric_normal_and_slope_assert.svh -----
// assertion macros for the photometric normal and slope block
// used by the port checker; no other dependencies
`ifndef PHOTOMETRIC_NORMAL_AND_SLOPE_ASSERT_SVH
`define PHOTOMETRIC_NORMAL_AND_SLOPE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PNS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pns assertion failed");

// next-cycle implication, disabled during reset
`define PNS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pns assertion failed");

`endif

// ----- hdl/pns_pkg.sv -----
// shared widths, constants, register codes and the lane output type
// for the photometric normal and slope block; no dependencies
`default_nettype none
package pns_pkg;
   localparam int PNS_LIGHTS  = 4;
   localparam int MAX_LIGHTS  = 4;
   localparam int COEF_W      = 16;
   localparam int PIX_W       = 8;
   localparam int PROD_W      = 24;
   localparam int RAW_W       = 26;
   localparam int MAG_W       = 25;
   localparam int SQ_W        = 50;
   localparam int SUM_W       = 52;
   localparam int RAD_W       = 60;
   localparam int ROOT_W      = 30;
   localparam int UNIT_NUM_W  = 43;
   localparam int UNIT_Q_W    = 15;
   localparam int NORM_W      = 16;
   localparam int NZ_W        = 15;
   localparam int SLOPE_NUM_W = 27;
   localparam int SLOPE_Q_W   = 26;
   localparam int SLOPE_W     = 20;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [NZ_W-1:0] Q14_ONE = 15'd16384;
   localparam logic [NZ_W-1:0] TINY_NZ = 15'd2;
   localparam logic [SLOPE_Q_W-1:0] SLOPE_POS_MAX = 26'd524287;
   localparam logic [SLOPE_Q_W-1:0] SLOPE_NEG_MAX = 26'd524288;

   localparam logic [CSR_IDX_W-1:0] CSR_PINV_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PINV_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PINV_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NZ = 2'd3;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [SQ_W-1:0]  sq;
   } lane_out_type;
endpackage
`default_nettype wire

// ----- hdl/pns_dot_lane.sv -----
// one lane: dot product of a pseudo-inverse row with the intensities,
// then magnitude and square; depends on pns_pkg
`default_nettype none
module pns_dot_lane import pns_pkg::*; #(
   parameter int LIGHTS = PNS_LIGHTS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [MAX_LIGHTS*COEF_W-1:0]  in_coef,
   input  wire logic [MAX_LIGHTS*PIX_W-1:0]   in_pix,
   output logic                               out_valid,
   output lane_out_type                       out_lane
);
   logic [MAX_LIGHTS-1:0][PROD_W-1:0] prod_in, prod_ff;
   logic [RAW_W-1:0] raw_in, raw_ff;
   logic [RAW_W-1:0] abs_full;
   logic [MAG_W-1:0] mag_in;
   logic [SQ_W-1:0]  sq_in;
   lane_out_type     lane_ff;
   logic [2:0]       vld_ff;

   always_comb begin
      logic signed [PROD_W:0] full;
      for (int k = 0; k < MAX_LIGHTS; k++) begin
         full = $signed(in_coef[COEF_W*k +: COEF_W]) * $signed({1'b0, in_pix[PIX_W*k +: PIX_W]});
         prod_in[k] = (k < LIGHTS) ? full[PROD_W-1:0] : '0;
      end
   end

   always_comb begin
      raw_in = '0;
      for (int k = 0; k < MAX_LIGHTS; k++) begin
         raw_in = raw_in + {{(RAW_W-PROD_W){prod_ff[k][PROD_W-1]}}, prod_ff[k]};
      end
   end

   assign abs_full = raw_ff[RAW_W-1] ? (~raw_ff + 1'b1) : raw_ff;
   assign mag_in   = abs_full[MAG_W-1:0];
   assign sq_in    = mag_in * mag_in;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         raw_ff      <= raw_in;
         lane_ff.neg <= raw_ff[RAW_W-1];
         lane_ff.mag <= mag_in;
         lane_ff.sq  <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[2];
   assign out_lane  = lane_ff;
endmodule
`default_nettype wire

// ----- hdl/pns_isqrt.sv -----
// pipelined integer square root, one result bit per stage
// carries a sideband word alongside; depends on pns_pkg
`default_nettype none
module pns_isqrt import pns_pkg::*; #(
   parameter int IN_W   = RAD_W,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [IN_W-1:0]     in_rad,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);
   localparam int STAGES = IN_W / 2;
   localparam logic [IN_W-1:0] BIT_TOP = IN_W'(1) << (IN_W - 2);

   logic [IN_W-1:0]   rem_prev [STAGES];
   logic [IN_W-1:0]   res_prev [STAGES];
   logic [SIDE_W-1:0] side_prev [STAGES];
   logic [IN_W-1:0]   rem_in [STAGES];
   logic [IN_W-1:0]   res_in [STAGES];
   logic [IN_W-1:0]   rem_ff [STAGES];
   logic [IN_W-1:0]   res_ff [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [STAGES-1:0] vld_ff;

   always_comb begin
      rem_prev[0]  = in_rad;
      res_prev[0]  = '0;
      side_prev[0] = in_side;
      for (int i = 1; i < STAGES; i++) begin
         rem_prev[i]  = rem_ff[i-1];
         res_prev[i]  = res_ff[i-1];
         side_prev[i] = side_ff[i-1];
      end
   end

   always_comb begin
      logic [IN_W-1:0] bit_v;
      logic [IN_W-1:0] trial;
      for (int i = 0; i < STAGES; i++) begin
         bit_v = BIT_TOP >> (2 * i);
         trial = res_prev[i] + bit_v;
         if (rem_prev[i] >= trial) begin
            rem_in[i] = rem_prev[i] - trial;
            res_in[i] = (res_prev[i] >> 1) + bit_v;
         end else begin
            rem_in[i] = rem_prev[i];
            res_in[i] = res_prev[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            res_ff[i]  <= res_in[i];
            side_ff[i] <= side_prev[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = res_ff[STAGES-1][IN_W/2-1:0];
   assign out_side  = side_ff[STAGES-1];
endmodule
`default_nettype wire

// ----- hdl/pns_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// carries a sideband word alongside; depends on pns_pkg
`default_nettype none
module pns_div import pns_pkg::*; #(
   parameter int NUM_W  = UNIT_NUM_W,
   parameter int DEN_W  = ROOT_W,
   parameter int Q_W    = UNIT_Q_W,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [NUM_W-1:0]    in_num,
   input  wire logic [DEN_W-1:0]    in_den,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [Q_W-1:0]           out_quot,
   output logic [SIDE_W-1:0]        out_side
);
   localparam int WW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [WW-1:0]     rem_prev [Q_W];
   logic [DEN_W-1:0]  den_prev [Q_W];
   logic [Q_W-1:0]    quo_prev [Q_W];
   logic [SIDE_W-1:0] side_prev [Q_W];
   logic [WW-1:0]     rem_in [Q_W];
   logic [Q_W-1:0]    quo_in [Q_W];
   logic [WW-1:0]     rem_ff [Q_W];
   logic [DEN_W-1:0]  den_ff [Q_W];
   logic [Q_W-1:0]    quo_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic [Q_W-1:0]    vld_ff;

   always_comb begin
      rem_prev[0]  = WW'(in_num);
      den_prev[0]  = in_den;
      quo_prev[0]  = '0;
      side_prev[0] = in_side;
      for (int i = 1; i < Q_W; i++) begin
         rem_prev[i]  = rem_ff[i-1];
         den_prev[i]  = den_ff[i-1];
         quo_prev[i]  = quo_ff[i-1];
         side_prev[i] = side_ff[i-1];
      end
   end

   always_comb begin
      logic [WW-1:0] shifted;
      for (int i = 0; i < Q_W; i++) begin
         shifted = WW'(den_prev[i]) << (Q_W - 1 - i);
         if (rem_prev[i] >= shifted) begin
            rem_in[i] = rem_prev[i] - shifted;
            quo_in[i] = quo_prev[i] | (Q_W'(1) << (Q_W - 1 - i));
         end else begin
            rem_in[i] = rem_prev[i];
            quo_in[i] = quo_prev[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Q_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_prev[i];
            quo_ff[i]  <= quo_in[i];
            side_ff[i] <= side_prev[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Q_W-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quot  = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];
endmodule
`default_nettype wire

// ----- hdl/photometric_normal_and_slope.sv -----
// top level of the photometric normal and slope block
// depends on pns_pkg, pns_dot_lane, pns_isqrt and pns_div
//
// Usage: one pixel per req_ transaction (mask bit and four intensities),
// one rsp_ transaction per pixel (unit normal in Q1.14, slopes in Q7.12,
// slope_valid), in the same order. Both channels are valid/ready.
// Load the three pseudo-inverse rows and the nz threshold over the csr_
// port while no pixel is in flight; csr_index 0..3 selects the register.
// Throughput: one pixel per cycle while req_ready is high. The pipeline has 77
// register stages (3 dot-product lane stages, 1 sum, 30 square-root stages,
// 15 stages of the three normalize dividers, 1 merge, 26 stages of the two
// slope dividers, 1 output register). The square root and dividers produce
// one bit per stage, which sets their stage counts.
// Reset clears every valid flag and the configuration registers to zero.
// When the receiver stalls, the result stays in the output register and
// the pipeline keeps moving until a finished pixel reaches its last stage;
// only then is req_ready pulled low.
`default_nettype none
module photometric_normal_and_slope import pns_pkg::*; #(
   parameter int LIGHTS = PNS_LIGHTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_in_mask,
   input  wire logic [PIX_W-1:0]      req_intensity_0,
   input  wire logic [PIX_W-1:0]      req_intensity_1,
   input  wire logic [PIX_W-1:0]      req_intensity_2,
   input  wire logic [PIX_W-1:0]      req_intensity_3,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [NORM_W-1:0]   rsp_normal_x,
   output logic signed [NORM_W-1:0]   rsp_normal_y,
   output logic [NZ_W-1:0]            rsp_normal_z,
   output logic signed [SLOPE_W-1:0]  rsp_slope_x,
   output logic signed [SLOPE_W-1:0]  rsp_slope_y,
   output logic                       rsp_slope_valid,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int SQ_SIDE_W = 2 + 3 + 3 * MAG_W;
   localparam int SX_SIDE_W = 2 * NORM_W + NZ_W + 1;

   // configuration registers
   logic [CSR_DATA_W-1:0] pinv_x_ff, pinv_y_ff, pinv_z_ff;
   logic [NZ_W-1:0]       min_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pinv_x_ff <= '0;
         pinv_y_ff <= '0;
         pinv_z_ff <= '0;
         min_nz_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PINV_X: pinv_x_ff <= csr_wdata;
            CSR_PINV_Y: pinv_y_ff <= csr_wdata;
            CSR_PINV_Z: pinv_z_ff <= csr_wdata;
            CSR_MIN_NZ: min_nz_ff <= csr_wdata[NZ_W-1:0];
            default:    ;
         endcase
      end
   end

   logic pipe_en;
   logic last_valid;

   assign pipe_en   = ~last_valid | ~rsp_valid | rsp_ready;
   assign req_ready = pipe_en;

   // dot-product lanes
   logic [MAX_LIGHTS*PIX_W-1:0] pix;
   lane_out_type lane_x, lane_y, lane_z;
   logic         lvx, lvy, lvz;
   logic [2:0]   mask_pipe_ff;

   assign pix = {req_intensity_3, req_intensity_2, req_intensity_1, req_intensity_0};

   pns_dot_lane #(.LIGHTS(LIGHTS)) u_lane_x (
      .clock, .reset, .en(pipe_en), .in_valid(req_valid), .in_coef(pinv_x_ff),
      .in_pix(pix), .out_valid(lvx), .out_lane(lane_x));
   pns_dot_lane #(.LIGHTS(LIGHTS)) u_lane_y (
      .clock, .reset, .en(pipe_en), .in_valid(req_valid), .in_coef(pinv_y_ff),
      .in_pix(pix), .out_valid(lvy), .out_lane(lane_y));
   pns_dot_lane #(.LIGHTS(LIGHTS)) u_lane_z (
      .clock, .reset, .en(pipe_en), .in_valid(req_valid), .in_coef(pinv_z_ff),
      .in_pix(pix), .out_valid(lvz), .out_lane(lane_z));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mask_pipe_ff <= {mask_pipe_ff[1:0], req_in_mask};
      end
   end

   // sum of squares
   logic [SUM_W-1:0]       sum_in, sum_ff;
   logic [SQ_SIDE_W-1:1]   sum_side_ff;
   logic                   sum_vld_ff;

   assign sum_in = SUM_W'(lane_x.sq) + SUM_W'(lane_y.sq) + SUM_W'(lane_z.sq);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff      <= sum_in;
         sum_side_ff <= {mask_pipe_ff[2], lane_x.neg, lane_y.neg, lane_z.neg,
                         lane_x.mag, lane_y.mag, lane_z.mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         sum_vld_ff <= lvx & lvy & lvz;
      end
   end

   // square root of 256 * sum
   logic                 sq_vld;
   logic [ROOT_W-1:0]    root;
   logic [SQ_SIDE_W-1:0] sq_side;
   logic                 s_mask, s_zero, s_nx, s_ny, s_nz;
   logic [MAG_W-1:0]     s_mx, s_my, s_mz;

   pns_isqrt #(.IN_W(RAD_W), .SIDE_W(SQ_SIDE_W)) u_isqrt (
      .clock, .reset, .en(pipe_en), .in_valid(sum_vld_ff),
      .in_rad({sum_ff, 8'b0}),
      .in_side({sum_ff == '0, sum_side_ff}),
      .out_valid(sq_vld), .out_root(root), .out_side(sq_side));

   assign {s_zero, s_mask, s_nx, s_ny, s_nz, s_mx, s_my, s_mz} = sq_side;

   // normalize lanes
   logic [UNIT_NUM_W-1:0] num_x, num_y, num_z;
   logic [UNIT_Q_W-1:0]   qx, qy, qz;
   logic                  dvx, dvy, dvz;
   logic [2:0]            dx_side;
   logic                  dy_neg, dz_neg;

   assign num_x = {s_mx, 18'b0} + UNIT_NUM_W'(root >> 1);
   assign num_y = {s_my, 18'b0} + UNIT_NUM_W'(root >> 1);
   assign num_z = {s_mz, 18'b0} + UNIT_NUM_W'(root >> 1);

   pns_div #(.NUM_W(UNIT_NUM_W), .DEN_W(ROOT_W), .Q_W(UNIT_Q_W), .SIDE_W(3)) u_div_x (
      .clock, .reset, .en(pipe_en), .in_valid(sq_vld), .in_num(num_x), .in_den(root),
      .in_side({s_mask, s_zero, s_nx}), .out_valid(dvx), .out_quot(qx), .out_side(dx_side));
   pns_div #(.NUM_W(UNIT_NUM_W), .DEN_W(ROOT_W), .Q_W(UNIT_Q_W), .SIDE_W(1)) u_div_y (
      .clock, .reset, .en(pipe_en), .in_valid(sq_vld), .in_num(num_y), .in_den(root),
      .in_side(s_ny), .out_valid(dvy), .out_quot(qy), .out_side(dy_neg));
   pns_div #(.NUM_W(UNIT_NUM_W), .DEN_W(ROOT_W), .Q_W(UNIT_Q_W), .SIDE_W(1)) u_div_z (
      .clock, .reset, .en(pipe_en), .in_valid(sq_vld), .in_num(num_z), .in_den(root),
      .in_side(s_nz), .out_valid(dvz), .out_quot(qz), .out_side(dz_neg));

   // merge: clamp, special cases, threshold
   logic [NZ_W-1:0]   cx, cy, cz;
   logic              force_up;
   logic [NORM_W-1:0] nx_in, ny_in, nx_ff, ny_ff;
   logic [NZ_W-1:0]   nz_in, nz_ff;
   logic              sv_in, sv_ff, mrg_vld_ff;

   assign cx = (qx > Q14_ONE) ? Q14_ONE : qx;
   assign cy = (qy > Q14_ONE) ? Q14_ONE : qy;
   assign cz = (qz > Q14_ONE) ? Q14_ONE : qz;
   assign force_up = ~dx_side[2] | dx_side[1] | (cz < TINY_NZ);
   assign nx_in = force_up ? '0 : (dx_side[0] ? -NORM_W'(cx) : NORM_W'(cx));
   assign ny_in = force_up ? '0 : (dy_neg ? -NORM_W'(cy) : NORM_W'(cy));
   assign nz_in = force_up ? Q14_ONE : cz;
   assign sv_in = dx_side[2] & (nz_in >= min_nz_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nz_ff <= nz_in;
         sv_ff <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mrg_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         mrg_vld_ff <= dvx & dvy & dvz & ~dz_neg | dvx & dvy & dvz & dz_neg;
      end
   end

   // slope lanes
   logic [NORM_W-1:0]      ax_full, ay_full;
   logic [SLOPE_NUM_W-1:0] snum_x, snum_y;
   logic [SLOPE_Q_W-1:0]   sqx, sqy;
   logic                   svx, svy;
   logic [SX_SIDE_W-1:0]   sx_side;
   logic                   sy_neg;
   logic [NORM_W-1:0]      o_nx, o_ny;
   logic [NZ_W-1:0]        o_nz;
   logic                   o_sv;

   assign ax_full = nx_ff[NORM_W-1] ? -nx_ff : nx_ff;
   assign ay_full = ny_ff[NORM_W-1] ? -ny_ff : ny_ff;
   assign snum_x = {ax_full[NZ_W-1:0], 12'b0} + SLOPE_NUM_W'(nz_ff >> 1);
   assign snum_y = {ay_full[NZ_W-1:0], 12'b0} + SLOPE_NUM_W'(nz_ff >> 1);

   pns_div #(.NUM_W(SLOPE_NUM_W), .DEN_W(NZ_W), .Q_W(SLOPE_Q_W), .SIDE_W(SX_SIDE_W))
   u_sdiv_x (
      .clock, .reset, .en(pipe_en), .in_valid(mrg_vld_ff), .in_num(snum_x), .in_den(nz_ff),
      .in_side({nx_ff, ny_ff, nz_ff, sv_ff}), .out_valid(svx), .out_quot(sqx),
      .out_side(sx_side));
   pns_div #(.NUM_W(SLOPE_NUM_W), .DEN_W(NZ_W), .Q_W(SLOPE_Q_W), .SIDE_W(1)) u_sdiv_y (
      .clock, .reset, .en(pipe_en), .in_valid(mrg_vld_ff), .in_num(snum_y), .in_den(nz_ff),
      .in_side(ny_ff[NORM_W-1]), .out_valid(svy), .out_quot(sqy), .out_side(sy_neg));

   assign {o_nx, o_ny, o_nz, o_sv} = sx_side;
   assign last_valid = svx & svy;

   function automatic logic [SLOPE_W-1:0] slope_sat(input logic neg,
                                                     input logic [SLOPE_Q_W-1:0] q);
      logic [SLOPE_W-1:0] r;
      if (neg) begin
         r = (q > SLOPE_POS_MAX) ? SLOPE_POS_MAX[SLOPE_W-1:0] : q[SLOPE_W-1:0];
      end else begin
         r = (q > SLOPE_NEG_MAX) ? SLOPE_NEG_MAX[SLOPE_W-1:0] : (~q[SLOPE_W-1:0] + 1'b1);
      end
      return r;
   endfunction

   // output register
   logic                rsp_valid_ff, rsp_sv_ff;
   logic [NORM_W-1:0]   rsp_nx_ff, rsp_ny_ff;
   logic [NZ_W-1:0]     rsp_nz_ff;
   logic [SLOPE_W-1:0]  rsp_sx_ff, rsp_sy_ff;
   logic                out_load;

   assign out_load = pipe_en & last_valid;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_nx_ff <= o_nx;
         rsp_ny_ff <= o_ny;
         rsp_nz_ff <= o_nz;
         rsp_sv_ff <= o_sv;
         rsp_sx_ff <= o_sv ? slope_sat(o_nx[NORM_W-1], sqx) : '0;
         rsp_sy_ff <= o_sv ? slope_sat(sy_neg, sqy) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normal_x    = rsp_nx_ff;
   assign rsp_normal_y    = rsp_ny_ff;
   assign rsp_normal_z    = rsp_nz_ff;
   assign rsp_slope_x     = rsp_sx_ff;
   assign rsp_slope_y     = rsp_sy_ff;
   assign rsp_slope_valid = rsp_sv_ff;
endmodule
`default_nettype wire

// ----- hdl/pns_checker.sv -----
// port-level checker for photometric_normal_and_slope and its bind
// depends on pns_pkg and photometric_normal_and_slope_assert.svh
`default_nettype none
`include "photometric_normal_and_slope_assert.svh"
module pns_checker import pns_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [NORM_W-1:0]     rsp_normal_x,
   input wire logic [NORM_W-1:0]     rsp_normal_y,
   input wire logic [NZ_W-1:0]       rsp_normal_z,
   input wire logic [SLOPE_W-1:0]    rsp_slope_x,
   input wire logic [SLOPE_W-1:0]    rsp_slope_y,
   input wire logic                  rsp_slope_valid
);
   logic [NORM_W*2+NZ_W+SLOPE_W*2:0] rsp_bundle;

   assign rsp_bundle = {rsp_normal_x, rsp_normal_y, rsp_normal_z,
                        rsp_slope_x, rsp_slope_y, rsp_slope_valid};

   // stalled transaction holds
   `PNS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bundle))
   // zeroed slopes when not computed
   `PNS_ASSERT_IMPL(a_slope_zero, rsp_valid && !rsp_slope_valid,
                    rsp_slope_x == '0 && rsp_slope_y == '0)
   // unit normal z stays in range
   `PNS_ASSERT_IMPL(a_nz_range, rsp_valid, rsp_normal_z <= Q14_ONE)
   // computed slopes never come from a tiny nz
   `PNS_ASSERT_IMPL(a_nz_tiny, rsp_valid && rsp_slope_valid, rsp_normal_z >= TINY_NZ)
endmodule

bind photometric_normal_and_slope pns_checker u_pns_checker (.*);
`default_nettype wire
